### hw/rtl/xdbt_pkg.sv
// Shared constants, codes and types for the XOR-distance bucket table.
package xdbt_pkg;

    // Default sizing of the table.
    localparam int NUM_BUCKETS_DEF = 128;
    localparam int BUCKET_SIZE_DEF = 8;
    localparam int HANDLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int ID_BITS         = 128;
    localparam int HALF_BITS       = 64;
    localparam int IN_HANDLE_BITS  = 16;
    localparam int CMD_BITS        = 2;
    localparam int STATUS_BITS     = 2;
    localparam int BUCKET_OUT_BITS = 7;
    localparam int COUNT_OUT_BITS  = 11;
    localparam int LZ_BITS         = 8;

    // Configuration port geometry: two 64-bit registers at 8-byte spacing.
    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 64;

    // Register index codes (address bit 3).
    localparam logic REG_SELF_HIGH = 1'b0;
    localparam logic REG_SELF_LOW  = 1'b1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD,
        CMD_TOUCH,
        CMD_LOOKUP,
        CMD_NEXT
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_PRESENT,
        ST_FULL
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LZC,
        S_FRD,
        S_FCHK,
        S_ECMP,
        S_MISS,
        S_AFRD,
        S_AFCHK,
        S_TRD,
        S_TWR,
        S_TLAST,
        S_NFRD,
        S_NFCHK,
        S_NOUT,
        S_EMIT
    } state_t;

endpackage

### hw/rtl/xdbt_if.sv
// Valid/ready channel interfaces for commands and results of the bucket table.
interface xdbt_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [xdbt_pkg::CMD_BITS-1:0]        command;
    logic [xdbt_pkg::HALF_BITS-1:0]       peer_id_high;
    logic [xdbt_pkg::HALF_BITS-1:0]       peer_id_low;
    logic [xdbt_pkg::IN_HANDLE_BITS-1:0]  peer_handle;

    modport source (output valid, command, peer_id_high, peer_id_low, peer_handle,
                    input ready);
    modport sink (input valid, command, peer_id_high, peer_id_low, peer_handle,
                  output ready);
endinterface

interface xdbt_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [xdbt_pkg::STATUS_BITS-1:0]      status;
    logic [xdbt_pkg::IN_HANDLE_BITS-1:0]   found_handle;
    logic [xdbt_pkg::HALF_BITS-1:0]        found_id_high;
    logic [xdbt_pkg::HALF_BITS-1:0]        found_id_low;
    logic [xdbt_pkg::BUCKET_OUT_BITS-1:0]  bucket_index;
    logic [xdbt_pkg::COUNT_OUT_BITS-1:0]   peer_count;

    modport source (output valid, status, found_handle, found_id_high, found_id_low,
                    bucket_index, peer_count, input ready);
    modport sink (input valid, status, found_handle, found_id_high, found_id_low,
                  bucket_index, peer_count, output ready);
endinterface

### hw/rtl/xor_distance_bucket_table_core.sv
// Operation: leading zeros of the distance are counted a byte at a time, then the buckets are
// scanned, each by a read of its fill count and a compare of its entries in turn; a next that
// misses searches circularly from the target bucket; a touch shifts later entries down.
// Throughput: one command at a time; a command is accepted only while the sequencer is idle.
// Reset: fill counts (via per-bucket valid bits), peer total and self ID clear at once;
// entry contents are undefined until written and need no clearing pass.
module xor_distance_bucket_table_core #(
    parameter int NUM_BUCKETS = xdbt_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_SIZE = xdbt_pkg::BUCKET_SIZE_DEF,
    parameter int HANDLE_BITS = xdbt_pkg::HANDLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [xdbt_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [xdbt_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [xdbt_pkg::PDATA_BITS-1:0]   prdata,
    output logic                              pready,
    xdbt_in_if.sink                           in_ch,
    xdbt_out_if.source                        out_ch
);
    import xdbt_pkg::*;

    localparam int SLOTS = NUM_BUCKETS * BUCKET_SIZE;
    localparam int BW    = $clog2(NUM_BUCKETS);
    localparam int FW    = $clog2(BUCKET_SIZE + 1);
    localparam int SW    = $clog2(SLOTS);
    localparam int TW    = $clog2(SLOTS + 1);
    localparam int EW    = ID_BITS + HANDLE_BITS;

    // Control registers.
    state_t                  state_reg, state_next;
    logic                    out_vld_reg, out_vld_next;
    logic [TW-1:0]           total_reg, total_next;
    logic [NUM_BUCKETS-1:0]  nz_reg, nz_next;
    logic [HALF_BITS-1:0]    self_hi_reg, self_lo_reg;

    // Working registers of the current command.
    cmd_t                    cmd_reg, cmd_next;
    logic [ID_BITS-1:0]      id_reg, id_next;
    logic [HANDLE_BITS-1:0]  hdl_reg, hdl_next;
    logic [ID_BITS-1:0]      dist_reg, dist_next;
    logic [LZ_BITS-1:0]      lz_reg, lz_next;
    logic [BW-1:0]           tb_reg, tb_next;
    logic [BW-1:0]           b_reg, b_next;
    logic [FW-1:0]           p_reg, p_next;
    logic [FW-1:0]           fill_reg, fill_next;
    logic [BW-1:0]           cnt_reg, cnt_next;
    logic [EW-1:0]           hold_reg, hold_next;

    // Pending result and output register.
    status_t                 rs_status_reg, rs_status_next;
    logic [HANDLE_BITS-1:0]  rs_hdl_reg, rs_hdl_next;
    logic [ID_BITS-1:0]      rs_id_reg, rs_id_next;
    logic [BW-1:0]           rs_bkt_reg, rs_bkt_next;
    status_t                 o_status_reg, o_status_next;
    logic [IN_HANDLE_BITS-1:0]  o_hdl_reg, o_hdl_next;
    logic [ID_BITS-1:0]      o_id_reg, o_id_next;
    logic [BUCKET_OUT_BITS-1:0] o_bkt_reg, o_bkt_next;
    logic [COUNT_OUT_BITS-1:0]  o_cnt_reg, o_cnt_next;

    // Memory ports.
    logic [EW-1:0]           ent_mem [SLOTS];
    logic [FW-1:0]           fill_mem [NUM_BUCKETS];
    logic                    ent_re, ent_we, fill_re, fill_we;
    logic [SW-1:0]           ent_ra, ent_wa;
    logic [EW-1:0]           ent_wd, ent_q;
    logic [BW-1:0]           fill_ra, fill_wa;
    logic [FW-1:0]           fill_wd, fill_q;

    logic [FW-1:0]           fill_eff;
    logic [ID_BITS-1:0]      ent_id;
    logic [HANDLE_BITS-1:0]  ent_hdl;
    logic [7:0]              top_byte;
    logic [LZ_BITS-1:0]      lz_fin, bk_raw;
    logic                    cfg_we;

    function automatic logic [SW-1:0] slot_of(logic [BW-1:0] b, logic [FW-1:0] p);
        return SW'(b * BUCKET_SIZE) + SW'(p);
    endfunction

    // Leading zeros of one byte; eight when the byte is zero.
    function automatic logic [3:0] lz8(logic [7:0] x);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (x[i]) begin
                n = 4'(7 - i);
            end
        end
        return n;
    endfunction

    // A bucket that was never filled reads as empty.
    assign fill_eff = nz_reg[b_reg] ? fill_q : '0;
    assign ent_id   = ent_q[EW-1 -: ID_BITS];
    assign ent_hdl  = ent_q[HANDLE_BITS-1:0];
    assign top_byte = dist_reg[ID_BITS-1 -: 8];
    assign lz_fin   = lz_reg + LZ_BITS'(lz8(top_byte));
    assign bk_raw   = (lz_fin == '0) ? '0 : lz_fin - LZ_BITS'(1);

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_SELF_LOW) ? self_lo_reg : self_hi_reg;

    // Channel outputs.
    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_vld_reg;
    assign out_ch.status        = o_status_reg;
    assign out_ch.found_handle  = o_hdl_reg;
    assign out_ch.found_id_high = o_id_reg[ID_BITS-1 -: HALF_BITS];
    assign out_ch.found_id_low  = o_id_reg[HALF_BITS-1:0];
    assign out_ch.bucket_index  = o_bkt_reg;
    assign out_ch.peer_count    = o_cnt_reg;

    // Command sequencer: scan, then act on the hit or miss.
    always_comb
    begin
        state_next     = state_reg;
        out_vld_next   = out_vld_reg;
        total_next     = total_reg;
        nz_next        = nz_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        hdl_next       = hdl_reg;
        dist_next      = dist_reg;
        lz_next        = lz_reg;
        tb_next        = tb_reg;
        b_next         = b_reg;
        p_next         = p_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        hold_next      = hold_reg;
        rs_status_next = rs_status_reg;
        rs_hdl_next    = rs_hdl_reg;
        rs_id_next     = rs_id_reg;
        rs_bkt_next    = rs_bkt_reg;
        o_status_next  = o_status_reg;
        o_hdl_next     = o_hdl_reg;
        o_id_next      = o_id_reg;
        o_bkt_next     = o_bkt_reg;
        o_cnt_next     = o_cnt_reg;
        ent_re  = 1'b0;
        ent_ra  = '0;
        ent_we  = 1'b0;
        ent_wa  = '0;
        ent_wd  = '0;
        fill_re = 1'b0;
        fill_ra = '0;
        fill_we = 1'b0;
        fill_wa = '0;
        fill_wd = '0;

        if (out_vld_reg && out_ch.ready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid) begin
                    cmd_next  = cmd_t'(in_ch.command);
                    id_next   = {in_ch.peer_id_high, in_ch.peer_id_low};
                    hdl_next  = HANDLE_BITS'(in_ch.peer_handle);
                    dist_next = {in_ch.peer_id_high, in_ch.peer_id_low}
                              ^ {self_hi_reg, self_lo_reg};
                    lz_next   = '0;
                    state_next = S_LZC;
                end
            end
            S_LZC:
            begin
                // Count leading zeros of the distance a byte per cycle.
                if (top_byte == '0 && lz_reg < LZ_BITS'(ID_BITS - 8)) begin
                    dist_next = dist_reg << 8;
                    lz_next   = lz_reg + LZ_BITS'(8);
                end else begin
                    if (bk_raw > LZ_BITS'(NUM_BUCKETS - 1)) begin
                        tb_next = BW'(NUM_BUCKETS - 1);
                    end else begin
                        tb_next = BW'(bk_raw);
                    end
                    b_next     = '0;
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                fill_re    = 1'b1;
                fill_ra    = b_reg;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (fill_eff == '0) begin
                    if (b_reg == BW'(NUM_BUCKETS - 1)) begin
                        state_next = S_MISS;
                    end else begin
                        b_next     = b_reg + BW'(1);
                        state_next = S_FRD;
                    end
                end else begin
                    fill_next  = fill_eff;
                    p_next     = '0;
                    ent_re     = 1'b1;
                    ent_ra     = slot_of(b_reg, '0);
                    state_next = S_ECMP;
                end
            end
            S_ECMP:
            begin
                // One stored entry compared per cycle, next read issued alongside.
                if (ent_id == id_reg) begin
                    hold_next = ent_q;
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            rs_status_next = ST_PRESENT;
                            rs_hdl_next    = ent_hdl;
                            rs_id_next     = ent_id;
                            rs_bkt_next    = b_reg;
                            state_next     = S_EMIT;
                        end
                        CMD_TOUCH:
                        begin
                            if (p_reg == fill_reg - FW'(1)) begin
                                rs_status_next = ST_OK;
                                rs_hdl_next    = ent_hdl;
                                rs_id_next     = ent_id;
                                rs_bkt_next    = b_reg;
                                state_next     = S_EMIT;
                            end else begin
                                state_next = S_TRD;
                            end
                        end
                        default:
                        begin
                            rs_status_next = ST_OK;
                            rs_hdl_next    = ent_hdl;
                            rs_id_next     = ent_id;
                            rs_bkt_next    = b_reg;
                            state_next     = S_EMIT;
                        end
                    endcase
                end else if ({1'b0, p_reg} + (FW+1)'(1) < {1'b0, fill_reg}) begin
                    p_next = p_reg + FW'(1);
                    ent_re = 1'b1;
                    ent_ra = slot_of(b_reg, p_reg + FW'(1));
                end else if (b_reg == BW'(NUM_BUCKETS - 1)) begin
                    state_next = S_MISS;
                end else begin
                    b_next     = b_reg + BW'(1);
                    state_next = S_FRD;
                end
            end
            S_MISS:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        b_next     = tb_reg;
                        state_next = S_AFRD;
                    end
                    CMD_NEXT:
                    begin
                        b_next     = tb_reg;
                        cnt_next   = '0;
                        state_next = S_NFRD;
                    end
                    default:
                    begin
                        rs_status_next = ST_NOT_FOUND;
                        rs_hdl_next    = '0;
                        rs_id_next     = '0;
                        rs_bkt_next    = '0;
                        state_next     = S_EMIT;
                    end
                endcase
            end
            S_AFRD:
            begin
                fill_re    = 1'b1;
                fill_ra    = b_reg;
                state_next = S_AFCHK;
            end
            S_AFCHK:
            begin
                rs_bkt_next = b_reg;
                state_next  = S_EMIT;
                if (fill_eff >= FW'(BUCKET_SIZE)) begin
                    rs_status_next = ST_FULL;
                    rs_hdl_next    = '0;
                    rs_id_next     = '0;
                end else begin
                    // Append at the tail of the target bucket.
                    ent_we         = 1'b1;
                    ent_wa         = slot_of(b_reg, fill_eff);
                    ent_wd         = {id_reg, hdl_reg};
                    fill_we        = 1'b1;
                    fill_wa        = b_reg;
                    fill_wd        = fill_eff + FW'(1);
                    nz_next[b_reg] = 1'b1;
                    total_next     = total_reg + TW'(1);
                    rs_status_next = ST_OK;
                    rs_hdl_next    = hdl_reg;
                    rs_id_next     = id_reg;
                end
            end
            S_TRD:
            begin
                ent_re     = 1'b1;
                ent_ra     = slot_of(b_reg, p_reg + FW'(1));
                state_next = S_TWR;
            end
            S_TWR:
            begin
                // Shift the following entry down by one place.
                ent_we = 1'b1;
                ent_wa = slot_of(b_reg, p_reg);
                ent_wd = ent_q;
                p_next = p_reg + FW'(1);
                if ({1'b0, p_reg} + (FW+1)'(2) == {1'b0, fill_reg}) begin
                    state_next = S_TLAST;
                end else begin
                    state_next = S_TRD;
                end
            end
            S_TLAST:
            begin
                ent_we         = 1'b1;
                ent_wa         = slot_of(b_reg, p_reg);
                ent_wd         = hold_reg;
                rs_status_next = ST_OK;
                rs_hdl_next    = hold_reg[HANDLE_BITS-1:0];
                rs_id_next     = hold_reg[EW-1 -: ID_BITS];
                rs_bkt_next    = b_reg;
                state_next     = S_EMIT;
            end
            S_NFRD:
            begin
                fill_re    = 1'b1;
                fill_ra    = b_reg;
                state_next = S_NFCHK;
            end
            S_NFCHK:
            begin
                // Circular search for the nearest non-empty bucket.
                if (fill_eff != '0) begin
                    ent_re     = 1'b1;
                    ent_ra     = slot_of(b_reg, '0);
                    state_next = S_NOUT;
                end else if (cnt_reg == BW'(NUM_BUCKETS - 1)) begin
                    rs_status_next = ST_NOT_FOUND;
                    rs_hdl_next    = '0;
                    rs_id_next     = '0;
                    rs_bkt_next    = '0;
                    state_next     = S_EMIT;
                end else begin
                    cnt_next = cnt_reg + BW'(1);
                    if (b_reg == BW'(NUM_BUCKETS - 1)) begin
                        b_next = '0;
                    end else begin
                        b_next = b_reg + BW'(1);
                    end
                    state_next = S_NFRD;
                end
            end
            S_NOUT:
            begin
                rs_status_next = ST_OK;
                rs_hdl_next    = ent_hdl;
                rs_id_next     = ent_id;
                rs_bkt_next    = b_reg;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_vld_reg || out_ch.ready) begin
                    o_status_next = rs_status_reg;
                    o_hdl_next    = IN_HANDLE_BITS'(rs_hdl_reg);
                    o_id_next     = rs_id_reg;
                    o_bkt_next    = BUCKET_OUT_BITS'(rs_bkt_reg);
                    o_cnt_next    = COUNT_OUT_BITS'(total_reg);
                    out_vld_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with asynchronous reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
            total_reg   <= '0;
            nz_reg      <= '0;
            self_hi_reg <= '0;
            self_lo_reg <= '0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
            total_reg   <= total_next;
            nz_reg      <= nz_next;
            if (cfg_we && paddr[2:0] == 3'b000) begin
                if (paddr[3] == REG_SELF_HIGH) begin
                    self_hi_reg <= pwdata;
                end else begin
                    self_lo_reg <= pwdata;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        hdl_reg       <= hdl_next;
        dist_reg      <= dist_next;
        lz_reg        <= lz_next;
        tb_reg        <= tb_next;
        b_reg         <= b_next;
        p_reg         <= p_next;
        fill_reg      <= fill_next;
        cnt_reg       <= cnt_next;
        hold_reg      <= hold_next;
        rs_status_reg <= rs_status_next;
        rs_hdl_reg    <= rs_hdl_next;
        rs_id_reg     <= rs_id_next;
        rs_bkt_reg    <= rs_bkt_next;
        o_status_reg  <= o_status_next;
        o_hdl_reg     <= o_hdl_next;
        o_id_reg      <= o_id_next;
        o_bkt_reg     <= o_bkt_next;
        o_cnt_reg     <= o_cnt_next;
    end

    // Entry memory; the sequencer never reads and writes one slot in the same cycle.
    always_ff @(posedge clk)
    begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_re) begin
            ent_q <= ent_mem[ent_ra];
        end
    end

    // Bucket fill memory.
    always_ff @(posedge clk)
    begin
        if (fill_we) begin
            fill_mem[fill_wa] <= fill_wd;
        end
        if (fill_re) begin
            fill_q <= fill_mem[fill_ra];
        end
    end

    // Checks on the table bookkeeping.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(SLOTS))
        else $error("peer total exceeds table size");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> (fill_wd != '0 && fill_wd <= FW'(BUCKET_SIZE)))
        else $error("bucket fill written out of range");

    a_total_follows_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |=> total_reg == $past(total_reg) + TW'(1))
        else $error("peer total not advanced with bucket fill");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> state_reg == S_LZC)
        else $error("accepted command did not start");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        ent_we |-> {1'b0, ent_wa} < (SW+1)'(SLOTS))
        else $error("entry write outside table");

endmodule
